### design/brle_pkg.sv
package brle_pkg;

  localparam int PIX_W = 8;
  localparam int BYTE_W = 8;
  localparam int SEG_W = 6;
  localparam int CNT_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int HDR_IDX_W = 3;
  localparam int QCNT_W = 2;

  localparam logic [BYTE_W-1:0] HDR_SYNC0 = 8'h7A;
  localparam logic [BYTE_W-1:0] HDR_SYNC1 = 8'h21;
  localparam logic [BYTE_W-1:0] RUN_SPLIT = 8'd190;
  localparam logic [BYTE_W-1:0] MARK_BASE = 8'd200;
  localparam logic [SEG_W-1:0] SEG_MAX = 6'd55;
  localparam logic [SEG_W-1:0] SEG_MIN = 6'd1;

  // Divider iterations: one quotient bit per cycle.
  localparam int DIV_STEPS = CNT_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [HDR_IDX_W-1:0] HDR_LEN_PLAIN = 3'd6;
  localparam logic [HDR_IDX_W-1:0] HDR_LEN_CHECKED = 3'd7;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHECKED_MODE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_SEGMENTS = 3'd4;

  // Header byte positions.
  localparam logic [HDR_IDX_W-1:0] HDR_POS_SYNC0A = 3'd0;
  localparam logic [HDR_IDX_W-1:0] HDR_POS_SYNC1A = 3'd1;
  localparam logic [HDR_IDX_W-1:0] HDR_POS_WIDTH = 3'd2;
  localparam logic [HDR_IDX_W-1:0] HDR_POS_HEIGHT = 3'd3;
  localparam logic [HDR_IDX_W-1:0] HDR_POS_SYNC0B = 3'd4;
  localparam logic [HDR_IDX_W-1:0] HDR_POS_SYNC1B = 3'd5;
  localparam logic [HDR_IDX_W-1:0] HDR_POS_SEGS = 3'd6;

  typedef struct packed {
    logic                 accept;
    logic                 code_step;
    logic                 out_load;
    logic                 out_from_hdr;
    logic [HDR_IDX_W-1:0] out_idx;
    logic                 out_last;
  } cmd_t;

  typedef struct packed {
    logic                 frame_start;
    logic                 div_done;
    logic [HDR_IDX_W-1:0] hdr_len;
    logic [QCNT_W-1:0]    code_count;
  } status_t;

  function automatic logic [BYTE_W-1:0] hdr_byte(
    input logic [HDR_IDX_W-1:0] idx,
    input logic [BYTE_W-1:0]    width,
    input logic [BYTE_W-1:0]    height,
    input logic [SEG_W-1:0]     segs
  );
    logic [BYTE_W-1:0] b;
    unique case (idx)
      HDR_POS_SYNC0A, HDR_POS_SYNC0B: b = HDR_SYNC0;
      HDR_POS_SYNC1A, HDR_POS_SYNC1B: b = HDR_SYNC1;
      HDR_POS_WIDTH:                  b = width;
      HDR_POS_HEIGHT:                 b = height;
      HDR_POS_SEGS:                   b = MARK_BASE + {2'b00, segs};
      default:                        b = HDR_SYNC0;
    endcase
    return b;
  endfunction

endpackage

### design/binary_image_run_length_encoder_unit.sv
// Binary image run-length encoder. Grey pixels arrive in raster order, one per
// input transfer; each is compared against the threshold register (above it is
// white) and the length of every finished colour run leaves as one byte on the
// output channel, with last_of_run marking the final byte a pixel causes. A
// pixel flagged as frame start first produces the header 7A 21 width height
// 7A 21, followed in checked mode by 200 plus the segment count, and restarts
// the coder. A pixel that is not a frame start passes through acceptance, a
// decision state and coding, then its output bytes are loaded one at a time
// as the output register frees up; the block takes no new pixel until the
// last byte of the previous one has been loaded. A frame-start pixel also
// waits for the iterative divider that derives the segment length from width
// times height, one quotient bit per cycle, and emits the header bytes first.
// The user must write the configuration through the plain write port only
// while the block is idle; the block itself does not enforce this.
module binary_image_run_length_encoder_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write_en,
  input  logic [brle_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [brle_pkg::BYTE_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [brle_pkg::PIX_W-1:0]     pixel_value,
  input  logic                           frame_start,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [brle_pkg::BYTE_W-1:0]    out_byte,
  output logic                           last_of_run
);
  import brle_pkg::*;

  // Commands flow from the controller to the datapath; status flows back.
  cmd_t    cmd;
  status_t status;

  // The controller sequences acceptance, division, coding and byte output.
  // The output register lives in the datapath, its valid flag in the
  // controller, so a new pixel may be accepted while the last byte waits.
  brle_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the configuration, the coder state, the divider and
  // the small queue of up to three coded bytes per pixel.
  brle_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_value  (pixel_value),
    .frame_start  (frame_start),
    .cmd          (cmd),
    .status       (status),
    .out_byte     (out_byte),
    .last_of_run  (last_of_run)
  );

endmodule

### design/brle_div.sv
module brle_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [brle_pkg::CNT_W-1:0]  dividend,
  input  logic [brle_pkg::SEG_W-1:0]  divisor,
  output logic [brle_pkg::CNT_W-1:0]  quotient,
  output logic                        done
);
  import brle_pkg::*;

  logic [CNT_W-1:0]     quo;
  logic [SEG_W-1:0]     rem;
  logic [SEG_W-1:0]     dvs;
  logic [DIV_CNT_W-1:0] steps;

  logic [SEG_W:0]       rem_sh;
  logic                 fits;
  logic [SEG_W:0]       rem_sub;

  // Restoring division, one quotient bit per cycle.
  assign rem_sh  = {rem, quo[CNT_W-1]};
  assign fits    = rem_sh >= {1'b0, dvs};
  assign rem_sub = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      steps <= DIV_CNT_W'(DIV_STEPS);
    end else if (steps != '0) begin
      steps <= steps - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (steps != '0) begin
      quo <= {quo[CNT_W-2:0], fits};
      rem <= fits ? rem_sub[SEG_W-1:0] : rem_sh[SEG_W-1:0];
    end
  end

  assign quotient = quo;
  assign done     = (steps == '0);

endmodule

### design/brle_dp.sv
module brle_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write_en,
  input  logic [brle_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [brle_pkg::BYTE_W-1:0]    cfg_data,
  input  logic [brle_pkg::PIX_W-1:0]     pixel_value,
  input  logic                           frame_start,
  input  brle_pkg::cmd_t                 cmd,
  output brle_pkg::status_t              status,
  output logic [brle_pkg::BYTE_W-1:0]    out_byte,
  output logic                           last_of_run
);
  import brle_pkg::*;

  // Configuration registers.
  logic [BYTE_W-1:0] threshold;
  logic [BYTE_W-1:0] frame_width;
  logic [BYTE_W-1:0] frame_height;
  logic              checked_mode;
  logic [SEG_W-1:0]  check_segments;

  // Coder state.
  logic              previous_white;
  logic [BYTE_W-1:0] run_length;
  logic [CNT_W-1:0]  pixel_counter;
  logic [CNT_W-1:0]  segment_length;
  logic [SEG_W-1:0]  checkpoint_counter;

  // Latched item and result bytes.
  logic [PIX_W-1:0]  pix;
  logic              start_lat;
  logic [BYTE_W-1:0] q0, q1, q2;

  logic [SEG_W-1:0]  seg_used;
  logic [CNT_W-1:0]  seg_quot;
  logic              div_done;

  logic              pw;
  logic [BYTE_W-1:0] rl;
  logic [CNT_W-1:0]  pc;
  logic [CNT_W-1:0]  sl;
  logic [SEG_W-1:0]  cc;
  logic [BYTE_W-1:0] rl_start;
  logic              white_px;
  logic              same;
  logic [BYTE_W-1:0] rl_inc;
  logic [CNT_W-1:0]  pc_inc;
  logic [SEG_W-1:0]  cc_inc;
  logic              cp;
  logic              sp;
  logic              pair;
  logic [BYTE_W-1:0] rl_mid;
  logic [BYTE_W-1:0] p0, p1;
  logic [QCNT_W-1:0] code_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold      <= 8'd128;
      frame_width    <= 8'd188;
      frame_height   <= 8'd120;
      checked_mode   <= 1'b0;
      check_segments <= 6'd10;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_THRESHOLD:      threshold      <= cfg_data;
        REG_FRAME_WIDTH:    frame_width    <= cfg_data;
        REG_FRAME_HEIGHT:   frame_height   <= cfg_data;
        REG_CHECKED_MODE:   checked_mode   <= cfg_data[0];
        REG_CHECK_SEGMENTS: check_segments <= cfg_data[SEG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (check_segments < SEG_MIN) begin
      seg_used = SEG_MIN;
    end else if (check_segments > SEG_MAX) begin
      seg_used = SEG_MAX;
    end else begin
      seg_used = check_segments;
    end
  end

  brle_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.accept & frame_start),
    .dividend ({8'd0, frame_width} * {8'd0, frame_height}),
    .divisor  (seg_used),
    .quotient (seg_quot),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      start_lat <= 1'b0;
    end else if (cmd.accept) begin
      start_lat <= frame_start;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix <= pixel_value;
    end
  end

  // A frame start restarts the coder before the pixel itself is coded.
  assign rl_start = checked_mode ? 8'd0 : 8'd1;
  assign pw       = start_lat | previous_white;
  assign rl       = start_lat ? rl_start : run_length;
  assign pc       = start_lat ? '0 : pixel_counter;
  assign cc       = start_lat ? '0 : checkpoint_counter;
  assign sl       = start_lat ? seg_quot : segment_length;

  assign white_px = pix > threshold;
  assign same     = (white_px == pw);
  assign rl_inc   = same ? rl + 8'd1 : 8'd1;
  assign pc_inc   = pc + 16'd1;
  assign cc_inc   = cc + 6'd1;
  assign cp       = checked_mode && (sl != '0) && (pc_inc == sl);
  assign rl_mid   = cp ? 8'd0 : rl_inc;
  assign sp       = (rl_mid == RUN_SPLIT);
  assign pair     = cp | sp;

  // The checkpoint or split contributes a pair of bytes after the run byte.
  assign p0 = cp ? rl_inc : (checked_mode ? RUN_SPLIT : RUN_SPLIT - 8'd1);
  assign p1 = cp ? MARK_BASE + {2'b00, cc_inc} : 8'd0;
  assign code_count = {1'b0, ~same} + (pair ? 2'd2 : 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_white     <= 1'b1;
      run_length         <= 8'd1;
      pixel_counter      <= '0;
      segment_length     <= '0;
      checkpoint_counter <= '0;
    end else if (cmd.code_step) begin
      previous_white     <= cp | white_px;
      run_length         <= sp ? rl_start : rl_mid;
      pixel_counter      <= checked_mode ? (cp ? '0 : pc_inc) : pc;
      segment_length     <= sl;
      checkpoint_counter <= cp ? cc_inc : cc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.code_step) begin
      if (!same) begin
        q0 <= rl;
        q1 <= p0;
        q2 <= p1;
      end else begin
        q0 <= p0;
        q1 <= p1;
        q2 <= 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      last_of_run <= cmd.out_last;
      if (cmd.out_from_hdr) begin
        out_byte <= hdr_byte(cmd.out_idx, frame_width, frame_height, seg_used);
      end else begin
        case (cmd.out_idx[QCNT_W-1:0])
          2'd0:    out_byte <= q0;
          2'd1:    out_byte <= q1;
          default: out_byte <= q2;
        endcase
      end
    end
  end

  assign status.frame_start = start_lat;
  assign status.div_done    = div_done;
  assign status.hdr_len     = checked_mode ? HDR_LEN_CHECKED : HDR_LEN_PLAIN;
  assign status.code_count  = code_count;

endmodule

### design/brle_ctrl.sv
module brle_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  brle_pkg::status_t status,
  output brle_pkg::cmd_t    cmd
);
  import brle_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_CODE = 3'd2;
  localparam logic [2:0] ST_HDR  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]           state, state_next;
  logic [HDR_IDX_W-1:0] idx, idx_next;
  logic [QCNT_W-1:0]    qcnt, qcnt_next;
  logic                 out_valid_next;
  logic                 can_load;
  logic                 hdr_end;
  logic                 q_end;

  assign can_load = !out_valid || out_ready;
  assign hdr_end  = (idx == status.hdr_len - 3'd1);
  assign q_end    = (idx[QCNT_W-1:0] == qcnt - 2'd1);
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next       = state;
    idx_next         = idx;
    qcnt_next        = qcnt;
    cmd              = '0;
    cmd.out_idx      = idx;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!status.frame_start || status.div_done) begin
          state_next = ST_CODE;
        end
      end
      ST_CODE: begin
        cmd.code_step = 1'b1;
        qcnt_next     = status.code_count;
        idx_next      = '0;
        if (status.frame_start) begin
          state_next = ST_HDR;
        end else if (status.code_count != '0) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_HDR: begin
        if (can_load) begin
          cmd.out_load     = 1'b1;
          cmd.out_from_hdr = 1'b1;
          cmd.out_last     = hdr_end && (qcnt == '0);
          if (hdr_end) begin
            idx_next   = '0;
            state_next = (qcnt != '0) ? ST_EMIT : ST_IDLE;
          end else begin
            idx_next = idx + 3'd1;
          end
        end
      end
      ST_EMIT: begin
        if (can_load) begin
          cmd.out_load = 1'b1;
          cmd.out_last = q_end;
          if (q_end) begin
            state_next = ST_IDLE;
          end else begin
            idx_next = idx + 3'd1;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      qcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      qcnt      <= qcnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### dv/binary_image_run_length_encoder_unit_tb.sv
module binary_image_run_length_encoder_unit_tb;
  import brle_pkg::*;

  // Scoreboard for the encoder. It keeps its own copy of the coder state and of
  // the configuration registers. Each accepted pixel is coded here into the
  // bytes that the block should produce. Each output transfer is then checked
  // against the oldest of those bytes.
  class rle_scoreboard;
    bit [7:0]  threshold;
    bit [7:0]  frame_w;
    bit [7:0]  frame_h;
    bit        checked;
    bit [5:0]  segments;
    bit        prev_white;
    bit [7:0]  run_len;
    bit [15:0] pix_count;
    bit [15:0] seg_len;
    bit [5:0]  mark_count;
    bit [8:0]  pending_bytes[$];  // {last_of_run, out_byte}
    int        errors;

    function new();
      threshold  = 8'd128;
      frame_w    = 8'd188;
      frame_h    = 8'd120;
      checked    = 1'b0;
      segments   = 6'd10;
      prev_white = 1'b1;
      run_len    = 8'd1;
      pix_count  = '0;
      seg_len    = '0;
      mark_count = '0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] index, bit [7:0] data);
      case (index)
        REG_THRESHOLD:      threshold = data;
        REG_FRAME_WIDTH:    frame_w = data;
        REG_FRAME_HEIGHT:   frame_h = data;
        REG_CHECKED_MODE:   checked = data[0];
        REG_CHECK_SEGMENTS: segments = data[5:0];
        default: ;
      endcase
    endfunction

    function void note_pixel(bit [7:0] pix, bit sof);
      bit [7:0] burst[$];
      bit [5:0] segs_used;
      bit       white;
      int       n;
      if (sof) begin
        segs_used = (segments < SEG_MIN) ? SEG_MIN : (segments > SEG_MAX) ? SEG_MAX : segments;
        burst = '{HDR_SYNC0, HDR_SYNC1, frame_w, frame_h, HDR_SYNC0, HDR_SYNC1};
        if (checked) burst.push_back(MARK_BASE + {2'b00, segs_used});
        prev_white = 1'b1;
        run_len    = checked ? 8'd0 : 8'd1;
        pix_count  = '0;
        mark_count = '0;
        seg_len    = ({8'd0, frame_w} * {8'd0, frame_h}) / {10'd0, segs_used};
      end
      white = pix > threshold;
      if (!checked) begin
        if (white == prev_white) begin
          run_len = run_len + 8'd1;
        end else begin
          burst.push_back(run_len);
          run_len = 8'd1;
        end
        if (run_len == RUN_SPLIT) begin
          burst.push_back(RUN_SPLIT - 8'd1);
          burst.push_back(8'd0);
          run_len = 8'd1;
        end
      end else begin
        pix_count = pix_count + 16'd1;
        if (white == prev_white) begin
          run_len = run_len + 8'd1;
        end else begin
          burst.push_back(run_len);
          run_len = 8'd1;
        end
        if (seg_len != 0 && pix_count == seg_len) begin
          mark_count = mark_count + 6'd1;
          burst.push_back(run_len);
          white = 1'b1;
          burst.push_back(MARK_BASE + {2'b00, mark_count});
          run_len   = 8'd0;
          pix_count = '0;
        end
        if (run_len == RUN_SPLIT) begin
          burst.push_back(RUN_SPLIT);
          burst.push_back(8'd0);
          run_len = 8'd0;
        end
      end
      prev_white = white;
      // A pixel never causes more than ten bytes; any beyond are dropped.
      n = (burst.size() > 10) ? 10 : burst.size();
      for (int i = 0; i < n; i++) pending_bytes.push_back({i == n - 1, burst[i]});
    endfunction

    function void check_byte(logic [7:0] value, logic last);
      bit [8:0] want;
      if (pending_bytes.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected output byte %02h last %0b", value, last);
        return;
      end
      want = pending_bytes.pop_front();
      if (want[7:0] !== value || want[8] !== last) begin
        errors++;
        if (errors <= 10)
          $display("byte mismatch: expected %02h last %0b, got %02h last %0b",
                   want[7:0], want[8], value, last);
      end
    endfunction

    function int pending();
      return pending_bytes.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_write_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0]    cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [PIX_W-1:0]     pixel_value;
  logic                 frame_start;
  logic                 out_valid;
  logic                 out_ready;
  logic [BYTE_W-1:0]    out_byte;
  logic                 last_of_run;

  rle_scoreboard sb = new();

  // Set by the stimulus once to ask the receiver for one long hold-off.
  bit hold_request;
  // When set, the sender offers pixels back to back for the current phase.
  bit tx_calm;

  binary_image_run_length_encoder_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write_en(cfg_write_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel_value (pixel_value),
    .frame_start (frame_start),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Gap after an input transfer: mostly none, sometimes a few cycles and now
  // and then a long one.
  function automatic int tx_gap();
    int r;
    if (tx_calm) return 0;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one pixel and holds it until the transfer happens. All inputs are
  // driven with nonblocking assignments at the rising edge, and in_ready is
  // read straight after the edge, so it holds the value the block presented
  // at that edge.
  task automatic send_pixel(input bit [7:0] pix, input bit sof);
    int gap;
    in_valid    <= 1'b1;
    pixel_value <= pix;
    frame_start <= sof;
    do @(posedge clk); while (!in_ready);
    sb.note_pixel(pix, sof);
    gap = tx_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // The write enable is left high here so that back-to-back writes do not
  // lower and raise it in the same step; program_regs lowers it at the end.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input bit [7:0] data);
    cfg_write_en <= 1'b1;
    cfg_index    <= index;
    cfg_data     <= data;
    @(posedge clk);
    sb.write_reg(index, data);
  endtask

  task automatic program_regs(input bit [7:0] thr, input bit [7:0] w, input bit [7:0] h,
                              input bit chk, input bit [5:0] segs);
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_CHECKED_MODE, {7'd0, chk});
    write_reg(REG_CHECK_SEGMENTS, {2'd0, segs});
    cfg_write_en <= 1'b0;
  endtask

  // Stops offering pixels and waits until every predicted byte has been
  // transferred. A pixel that only extends a run causes no byte, so the block
  // may still be busy with it: a further margin of cycles follows before the
  // block is treated as idle.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Output side. Every output transfer goes to the scoreboard. The ready line
  // alternates between calm stretches and stretches with random stalls, most
  // of them short and a few long. On request it gives its long hold-off so
  // that the block fills up and stops taking pixels.
  initial begin : receiver
    int stall;
    int span;
    bit calm;
    stall     = 0;
    span      = 0;
    calm      = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) sb.check_byte(out_byte, last_of_run);
      if (hold_request) begin
        hold_request = 1'b0;
        stall = 400;
      end
      if (span == 0) begin
        calm = ($urandom_range(0, 3) == 0);
        span = $urandom_range(50, 200);
      end else begin
        span--;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    bit [7:0] thr;
    bit [7:0] w;
    bit [7:0] h;
    bit [5:0] segs;
    bit       chk;
    bit       mid;
    bit       sof;
    bit [7:0] pix;
    int       area;
    int       len;
    int       nframes;
    int       random_items;
    int       long_kind;

    rst          = 1'b1;
    cfg_write_en = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    pixel_value  = '0;
    frame_start  = 1'b0;
    hold_request = 1'b0;
    tx_calm      = 1'b0;
    random_items = 0;
    pix          = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset values, plain coding, no frame seen yet. The threshold itself
    // counts as black and one above it as white.
    send_pixel(8'd128, 1'b0);
    send_pixel(8'd129, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b0);
    settle();

    // Checked coding before any frame start: the segment length is still
    // zero, so no checkpoint markers may appear.
    program_regs(8'd128, 8'd188, 8'd120, 1'b1, 6'd10);
    send_pixel(8'd200, 1'b0);
    send_pixel(8'd10, 1'b0);
    send_pixel(8'd10, 1'b0);
    send_pixel(8'd255, 1'b0);
    settle();

    // A 2x2 frame with a segment count of zero, which the block treats as one.
    // The pixels after the fourth run past the end of the frame.
    program_regs(8'd100, 8'd2, 8'd2, 1'b1, 6'd0);
    send_pixel(8'd0, 1'b1);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd101, 1'b0);
    send_pixel(8'd100, 1'b0);
    settle();

    // A 1x1 frame with one segment: a black first pixel yields the full burst
    // of ten bytes (header, run, flushed run and checkpoint marker).
    program_regs(8'd128, 8'd1, 8'd1, 1'b1, 6'd1);
    send_pixel(8'd0, 1'b1);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b0);
    settle();

    // Largest frame and a segment count above the limit, so 55 is used, also
    // in the header. Nothing exceeds the top threshold.
    program_regs(8'd255, 8'd255, 8'd255, 1'b1, 6'd63);
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd0, 1'b0);
    settle();

    // A zero width makes the segment length zero.
    program_regs(8'd0, 8'd0, 8'd7, 1'b1, 6'd55);
    send_pixel(8'd0, 1'b1);
    send_pixel(8'd1, 1'b0);
    settle();

    // Plain frame start.
    program_regs(8'd0, 8'd255, 8'd1, 1'b0, 6'd55);
    send_pixel(8'd1, 1'b1);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b0);
    settle();

    // One long phase, picked at random: a long white run in plain mode, split
    // as 189 followed by 0; a long black run in checked mode with one huge
    // segment, split as 190 followed by 0; or one pixel per segment kept up
    // well past the frame end, so that the checkpoint counter wraps and the
    // marker byte wraps past 255. The receiver is asked for its long hold-off
    // at the frame start while pixels keep coming.
    long_kind = $urandom_range(0, 2);
    case (long_kind)
      0: begin
        tx_calm = ($urandom_range(0, 1) == 0);
        program_regs(8'd0, 8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)), 1'b0,
                     6'($urandom_range(0, 63)));
        hold_request = 1'b1;
        send_pixel(8'($urandom_range(1, 255)), 1'b1);
        for (int i = 0; i < 195; i++) send_pixel(8'($urandom_range(1, 255)), 1'b0);
      end
      1: begin
        tx_calm = ($urandom_range(0, 1) == 0);
        program_regs(8'd255, 8'd255, 8'd255, 1'b1, 6'd1);
        hold_request = 1'b1;
        send_pixel(8'($urandom_range(0, 255)), 1'b1);
        for (int i = 0; i < 195; i++) send_pixel(8'($urandom_range(0, 255)), 1'b0);
      end
      default: begin
        tx_calm = 1'b1;
        program_regs(8'($urandom_range(0, 255)), 8'd1, 8'd1, 1'b1, 6'd1);
        hold_request = 1'b1;
        send_pixel(8'($urandom_range(0, 255)), 1'b1);
        for (int i = 0; i < 69; i++) send_pixel(8'($urandom_range(0, 255)), 1'b0);
      end
    endcase
    settle();

    // Random phases: a fresh setting each time, then mostly well-formed frames
    // of small size with random content. Some frames are a little too long or
    // too short, a stray frame start turns up now and then, and some phases go
    // on from the previous state without a frame start, which changes the
    // mode in the middle of a frame.
    while (random_items < 60) begin
      case ($urandom_range(0, 9))
        0: thr = 8'd0;
        1: thr = 8'd255;
        default: thr = 8'($urandom_range(0, 255));
      endcase
      w    = ($urandom_range(0, 19) == 0) ? 8'd255 : 8'($urandom_range(1, 8));
      h    = ($urandom_range(0, 19) == 0) ? 8'd255 : 8'($urandom_range(1, 6));
      area = int'(w) * int'(h);
      case ($urandom_range(0, 9))
        0: segs = 6'd0;
        1: segs = 6'($urandom_range(56, 63));
        2: segs = 6'd55;
        default: segs = 6'($urandom_range(1, (area < 55) ? area : 55));
      endcase
      chk     = ($urandom_range(0, 9) < 7);
      mid     = ($urandom_range(0, 6) == 0);
      nframes = $urandom_range(1, 3);
      tx_calm = ($urandom_range(0, 3) == 0);
      program_regs(thr, w, h, chk, segs);
      for (int f = 0; f < nframes; f++) begin
        len = (area > 30) ? int'($urandom_range(5, 30)) : area;
        case ($urandom_range(0, 7))
          0: len = len + int'($urandom_range(1, 3));
          1: if (len > 1) len = len - 1;
          default: ;
        endcase
        for (int i = 0; i < len; i++) begin
          sof = (i == 0 && !(mid && f == 0)) || ($urandom_range(0, 39) == 0);
          // Pixels often repeat so that runs of one colour build up.
          if (i == 0 || $urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 5))
              0: pix = thr;
              1: pix = thr + 8'd1;
              default: pix = 8'($urandom_range(0, 255));
            endcase
          end
          send_pixel(pix, sof);
          random_items++;
        end
      end
      settle();
    end

    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("Verification failed");
    $finish;
  end

endmodule

### sim.f
design/brle_pkg.sv
design/brle_div.sv
design/brle_dp.sv
design/brle_ctrl.sv
design/binary_image_run_length_encoder_unit.sv
dv/binary_image_run_length_encoder_unit_tb.sv
